[rtl/max_xor_binary_trie_core_assert.svh]
// Assertion macros shared by the trie core.
`ifndef MAX_XOR_BINARY_TRIE_CORE_ASSERT_SVH
`define MAX_XOR_BINARY_TRIE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MXT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trie core assertion failed");

// Next-cycle implication, checked outside reset
`define MXT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trie core assertion failed");

`endif

[rtl/mxt_pkg.sv]
`timescale 1ns / 1ps
package mxt_pkg;

    localparam int KEY_BITS   = 31;
    localparam int NODE_COUNT = 32768;
    localparam int LINK_W     = $clog2(NODE_COUNT);
    localparam int FREE_W     = LINK_W + 1;
    localparam int ENTRY_W    = 2 * LINK_W;
    localparam int LEVEL_W    = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int SUM_W      = FREE_W + 1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_ANSWERED = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_ALLOC
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        logic    walk_step;
        logic    link_parent;
        logic    alloc_step;
        logic    finish;
        t_status code;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_query;
        logic root_empty;
        logic link_missing;
        logic last_level;
        logic pool_short;
    } t_dp_status;

endpackage

[rtl/mxt_ctrl.sv]
`timescale 1ns / 1ps
module mxt_ctrl import mxt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_dp_status i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.is_query) begin
                    if (i_stat.root_empty || i_stat.last_level) begin
                        n_state = S_IDLE;
                    end
                end else if (i_stat.link_missing) begin
                    n_state = i_stat.pool_short ? S_IDLE : S_ALLOC;
                end else if (i_stat.last_level) begin
                    n_state = S_IDLE;
                end
            end
            S_ALLOC: begin
                if (i_stat.last_level) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.code = ST_INSERTED;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_WALK: begin
                if (i_stat.is_query) begin
                    if (i_stat.root_empty) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.code   = ST_EMPTY;
                    end else begin
                        o_cmd.walk_step = 1'b1;
                        o_cmd.finish    = i_stat.last_level;
                        o_cmd.code      = ST_ANSWERED;
                    end
                end else if (i_stat.link_missing) begin
                    if (i_stat.pool_short) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.code   = ST_FULL;
                    end else begin
                        o_cmd.link_parent = 1'b1;
                    end
                end else begin
                    // Existing path; a full path is a duplicate
                    o_cmd.walk_step = 1'b1;
                    o_cmd.finish    = i_stat.last_level;
                end
            end
            S_ALLOC: begin
                o_cmd.alloc_step = 1'b1;
                o_cmd.finish     = i_stat.last_level;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[rtl/mxt_datapath.sv]
`timescale 1ns / 1ps
module mxt_datapath import mxt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic                i_func,
    input  logic [KEY_BITS-1:0] i_operand,
    output t_dp_status          o_stat,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [KEY_BITS-1:0] o_best_xor,
    output logic [KEY_BITS-1:0] o_matched_value
);

    localparam logic [SUM_W-1:0] NODE_LIMIT = SUM_W'(NODE_COUNT);

    logic [ENTRY_W-1:0]  mem [NODE_COUNT];
    logic [ENTRY_W-1:0]  r_rdata;
    logic [ENTRY_W-1:0]  r_root;
    logic [FREE_W-1:0]   r_free;
    logic                r_func;
    logic [KEY_BITS-1:0] r_key;
    logic [LEVEL_W-1:0]  r_level;
    logic [LINK_W-1:0]   r_node;
    logic [KEY_BITS-1:0] r_value;
    logic                r_valid;
    t_status             r_status;
    logic [KEY_BITS-1:0] r_best;
    logic [KEY_BITS-1:0] r_match;

    logic [ENTRY_W-1:0]  cur_entry;
    logic                key_bit;
    logic [LINK_W-1:0]   link_same;
    logic [LINK_W-1:0]   link_other;
    logic                take_other;
    logic                take_bit;
    logic [LINK_W-1:0]   next_link;
    logic [KEY_BITS-1:0] step_value;
    logic [LEVEL_W-1:0]  level_below;
    logic                alloc_bit;
    logic [LINK_W-1:0]   fresh_child;
    logic [ENTRY_W-1:0]  alloc_entry;
    logic [ENTRY_W-1:0]  parent_entry;
    logic [SUM_W-1:0]    need_end;
    logic                wr_en;
    logic [LINK_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0]  wr_data;

    // Current node's links: the root lives in registers, others in memory
    assign cur_entry  = (r_node == '0) ? r_root : r_rdata;
    assign key_bit    = r_key[r_level];
    assign link_same  = key_bit ? cur_entry[ENTRY_W-1:LINK_W] : cur_entry[LINK_W-1:0];
    assign link_other = key_bit ? cur_entry[LINK_W-1:0] : cur_entry[ENTRY_W-1:LINK_W];

    // Prefer the opposite bit on a query
    assign take_other = r_func && (link_other != '0);
    assign take_bit   = take_other ? ~key_bit : key_bit;
    assign next_link  = take_other ? link_other : link_same;
    assign step_value = r_value | ({{(KEY_BITS-1){1'b0}}, take_bit} << r_level);

    // Pool end once the nodes still needed, current level down to the leaf, are taken
    assign need_end = {1'b0, r_free} + SUM_W'(r_level) + SUM_W'(1);

    assign o_stat.is_query     = r_func;
    assign o_stat.root_empty   = (r_root == '0);
    assign o_stat.link_missing = (link_same == '0);
    assign o_stat.last_level   = (r_level == '0);
    assign o_stat.pool_short   = (need_end > NODE_LIMIT);

    // Fresh node points to the next fresh node, the leaf to nothing
    assign level_below = r_level - LEVEL_W'(1);
    assign alloc_bit   = (r_level == '0) ? 1'b0 : r_key[level_below];
    assign fresh_child = r_free[LINK_W-1:0] + LINK_W'(1);
    always_comb begin
        if (r_level == '0) begin
            alloc_entry = '0;
        end else if (alloc_bit) begin
            alloc_entry = {fresh_child, {LINK_W{1'b0}}};
        end else begin
            alloc_entry = {{LINK_W{1'b0}}, fresh_child};
        end
    end

    // Hook the first fresh node under the node where the walk stopped
    assign parent_entry = key_bit ? {r_free[LINK_W-1:0], cur_entry[LINK_W-1:0]}
                                  : {cur_entry[ENTRY_W-1:LINK_W], r_free[LINK_W-1:0]};

    assign wr_en   = i_cmd.alloc_step || (i_cmd.link_parent && (r_node != '0));
    assign wr_addr = i_cmd.alloc_step ? r_free[LINK_W-1:0] : r_node;
    assign wr_data = i_cmd.alloc_step ? alloc_entry : parent_entry;

    // Node memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step) begin
            r_rdata <= mem[next_link];
        end
    end

    // Root links and pool pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
            r_free <= FREE_W'(1);
        end else begin
            if (i_cmd.link_parent && (r_node == '0)) begin
                r_root <= parent_entry;
            end
            if (i_cmd.alloc_step) begin
                r_free <= r_free + FREE_W'(1);
            end
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_key   <= i_operand;
            r_level <= LEVEL_W'(KEY_BITS - 1);
            r_node  <= '0;
            r_value <= '0;
        end else if (i_cmd.walk_step) begin
            r_node  <= next_link;
            r_level <= level_below;
            r_value <= step_value;
        end else if (i_cmd.alloc_step) begin
            r_level <= level_below;
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status <= i_cmd.code;
            if (i_cmd.code == ST_ANSWERED) begin
                r_match <= step_value;
                r_best  <= step_value ^ r_key;
            end else begin
                r_match <= '0;
                r_best  <= '0;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_best_xor      = r_best;
    assign o_matched_value = r_match;

endmodule

[rtl/max_xor_binary_trie_core.sv]
`timescale 1ns / 1ps
// Query: one trie level per node-memory read; an empty trie is answered without a walk.
// Insert: walks the existing levels, links the first new node to its parent, then makes one
// node-memory write per new node. Pool-full reject ends the walk early.
// One item at a time; o_valid follows the last busy cycle, when a new start is taken.
// Synchronous active-low reset empties the trie at once; node memory needs no clearing.
// Results cannot be stalled: each one is shown for exactly one cycle.
`include "max_xor_binary_trie_core_assert.svh"
module max_xor_binary_trie_core import mxt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_func,
    input  logic [KEY_BITS-1:0] i_operand,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [KEY_BITS-1:0] o_best_xor,
    output logic [KEY_BITS-1:0] o_matched_value
);

    t_dp_cmd    w_cmd;
    t_dp_status w_stat;
    logic [3:0] w_actions;

    mxt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    mxt_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_func          (i_func),
        .i_operand       (i_operand),
        .o_stat          (w_stat),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_best_xor      (o_best_xor),
        .o_matched_value (o_matched_value)
    );

    // Gather the datapath actions for the one-hot check
    assign w_actions = {w_cmd.load, w_cmd.walk_step, w_cmd.link_parent, w_cmd.alloc_step};

    // Accepted item keeps the core busy
    `MXT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // At most one datapath action a cycle
    `MXT_ASSERT_IMP(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(w_actions))
    // Finishing frees the core and strobes the result
    `MXT_ASSERT_NXT(a_finish_strobe, i_clk, i_rst_n, w_cmd.finish, o_valid && !busy)
    // No result without a finish
    `MXT_ASSERT_IMP(a_strobe_cause, i_clk, i_rst_n, o_valid, $past(w_cmd.finish))

endmodule

[tb/max_xor_binary_trie_core_tb.sv]
`timescale 1ns / 1ps
module max_xor_binary_trie_core_tb;
    import mxt_pkg::*;

    localparam bit OP_INSERT = 1'b0;
    localparam bit OP_QUERY  = 1'b1;

    localparam logic [KEY_BITS-1:0] KEY_ZERO = '0;
    localparam logic [KEY_BITS-1:0] KEY_ONES = '1;

    localparam int RANDOM_ITEMS = 500;
    localparam int FILL_CAP     = 3000;
    localparam int FULL_REJECTS = 25;
    localparam int POST_ITEMS   = 120;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 1_200_000;
    localparam int PRINT_CAP    = 100;

    typedef struct packed {
        t_status             status;
        logic [KEY_BITS-1:0] best_xor;
        logic [KEY_BITS-1:0] matched_value;
    } trie_result_t;

    typedef struct packed {
        bit                  op;
        logic [KEY_BITS-1:0] key;
        bit                  typed;
        trie_result_t        res;
    } dir_row_t;

    localparam trie_result_t NO_RES = '0;
    localparam int DIR_COUNT = 20;

    // Directed items: empty set, extremes, duplicates, alternating patterns
    dir_row_t dir_rows [DIR_COUNT] = '{
        '{OP_QUERY,  KEY_ZERO,      1'b1, '{ST_EMPTY,    KEY_ZERO, KEY_ZERO}},
        '{OP_QUERY,  KEY_ONES,      1'b1, '{ST_EMPTY,    KEY_ZERO, KEY_ZERO}},
        '{OP_INSERT, KEY_ZERO,      1'b1, '{ST_INSERTED, KEY_ZERO, KEY_ZERO}},
        '{OP_QUERY,  KEY_ZERO,      1'b1, '{ST_ANSWERED, KEY_ZERO, KEY_ZERO}},
        '{OP_QUERY,  KEY_ONES,      1'b1, '{ST_ANSWERED, KEY_ONES, KEY_ZERO}},
        '{OP_INSERT, KEY_ZERO,      1'b1, '{ST_INSERTED, KEY_ZERO, KEY_ZERO}},
        '{OP_INSERT, KEY_ONES,      1'b1, '{ST_INSERTED, KEY_ZERO, KEY_ZERO}},
        '{OP_QUERY,  KEY_ZERO,      1'b1, '{ST_ANSWERED, KEY_ONES, KEY_ONES}},
        '{OP_QUERY,  KEY_ONES,      1'b1, '{ST_ANSWERED, KEY_ONES, KEY_ZERO}},
        '{OP_QUERY,  31'h4000_0000, 1'b0, NO_RES},
        '{OP_QUERY,  31'h3FFF_FFFF, 1'b0, NO_RES},
        '{OP_INSERT, 31'h5555_5555, 1'b1, '{ST_INSERTED, KEY_ZERO, KEY_ZERO}},
        '{OP_INSERT, 31'h2AAA_AAAA, 1'b1, '{ST_INSERTED, KEY_ZERO, KEY_ZERO}},
        '{OP_QUERY,  31'h5555_5555, 1'b0, NO_RES},
        '{OP_QUERY,  31'h2AAA_AAAA, 1'b0, NO_RES},
        '{OP_INSERT, 31'h0000_0001, 1'b1, '{ST_INSERTED, KEY_ZERO, KEY_ZERO}},
        '{OP_QUERY,  31'h0000_0001, 1'b0, NO_RES},
        '{OP_INSERT, 31'h4000_0000, 1'b0, NO_RES},
        '{OP_QUERY,  31'h4000_0000, 1'b0, NO_RES},
        '{OP_INSERT, KEY_ONES,      1'b1, '{ST_INSERTED, KEY_ZERO, KEY_ZERO}}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_func;
    logic [KEY_BITS-1:0] i_operand;
    logic                o_valid;
    logic [1:0]          o_status;
    logic [KEY_BITS-1:0] o_best_xor;
    logic [KEY_BITS-1:0] o_matched_value;

    // Shadow trie: slot 0 holds the root links
    int unsigned kid_link [NODE_COUNT][2];
    int unsigned free_node;

    trie_result_t        pending_results [$];
    logic [KEY_BITS-1:0] stored_keys [$];
    trie_result_t        want_res;
    int                  errors;
    int                  cycle_count;
    int                  burst_left;
    int                  gap_left;

    max_xor_binary_trie_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_operand       (i_operand),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_best_xor      (o_best_xor),
        .o_matched_value (o_matched_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what);
        if (errors < PRINT_CAP) begin
            $display("%0t: %s", $time, what);
        end
        errors++;
    endtask

    // Apply one item to the shadow trie and work out its result
    function automatic trie_result_t trie_apply(input bit op, input logic [KEY_BITS-1:0] key);
        trie_result_t res;
        int unsigned  node;
        int unsigned  fresh;
        int           lvl;
        bit           b;
        res  = '0;
        node = 0;
        if (op == OP_INSERT) begin
            lvl = KEY_BITS - 1;
            // follow the existing part of the path
            while (lvl >= 0) begin
                if (kid_link[node][key[lvl]] == 0) break;
                node = kid_link[node][key[lvl]];
                lvl--;
            end
            if (free_node + lvl + 1 > NODE_COUNT) begin
                res.status = ST_FULL;
            end else begin
                // allocate the missing levels down to the leaf
                while (lvl >= 0) begin
                    fresh = free_node;
                    free_node++;
                    kid_link[fresh][0] = 0;
                    kid_link[fresh][1] = 0;
                    kid_link[node][key[lvl]] = fresh;
                    node = fresh;
                    lvl--;
                end
                res.status = ST_INSERTED;
            end
        end else if (kid_link[0][0] == 0 && kid_link[0][1] == 0) begin
            res.status = ST_EMPTY;
        end else begin
            // prefer the opposite bit at each level
            for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
                b = key[lvl];
                if (kid_link[node][!b] != 0) begin
                    node = kid_link[node][!b];
                    res.matched_value[lvl] = !b;
                end else begin
                    node = kid_link[node][b];
                    res.matched_value[lvl] = b;
                end
            end
            res.status   = ST_ANSWERED;
            res.best_xor = res.matched_value ^ key;
        end
        return res;
    endfunction

    function automatic logic [KEY_BITS-1:0] rand_bits();
        logic [31:0] r;
        r = $urandom();
        return r[KEY_BITS-1:0];
    endfunction

    function automatic logic [KEY_BITS-1:0] rand_key();
        logic [KEY_BITS-1:0] k;
        case ($urandom_range(0, 9))
            0: k = KEY_ZERO;
            1: k = KEY_ONES;
            2: k = KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1);
            3: k = ~(KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1));
            default: k = rand_bits();
        endcase
        return k;
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_stored();
        if (stored_keys.size() == 0) return rand_key();
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    endfunction

    // Keep the upper bits of a key, flip one level and randomise below it
    function automatic logic [KEY_BITS-1:0] near_key(input logic [KEY_BITS-1:0] base,
                                                     input int top_lvl);
        int                  lvl;
        logic [KEY_BITS-1:0] low_mask;
        logic [KEY_BITS-1:0] k;
        lvl      = $urandom_range(0, top_lvl);
        low_mask = (KEY_BITS'(1) << lvl) - 1'b1;
        k        = base ^ (KEY_BITS'(1) << lvl);
        return (k & ~low_mask) | (rand_bits() & low_mask);
    endfunction

    // Offer one item, hold it until taken, then record what it should give
    task automatic send_item(input bit op, input logic [KEY_BITS-1:0] key,
                             input bit typed, input trie_result_t typed_res,
                             output t_status st);
        trie_result_t predicted;
        if (gap_left > 0) begin
            start     <= 1'b0;
            i_func    <= 1'($urandom_range(0, 1));
            i_operand <= rand_bits();
            repeat (gap_left) @(posedge i_clk);
            gap_left = 0;
        end
        start     <= 1'b1;
        i_func    <= op;
        i_operand <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = trie_apply(op, key);
        pending_results.push_back(typed ? typed_res : predicted);
        st = predicted.status;
        if (op == OP_INSERT && predicted.status == ST_INSERTED) begin
            stored_keys.push_back(key);
        end
        // end of burst: pick the next gap so it lands on varied phases of the walk
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 40)
                                                     : $urandom_range(1, 34);
        end
    endtask

    // Drop start and hold off until every pending result has come
    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0) begin
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing pending: st=%0d xor=%h val=%h",
                                 o_status, o_best_xor, o_matched_value));
            end else begin
                want_res = pending_results.pop_front();
                if (o_status !== want_res.status || o_best_xor !== want_res.best_xor
                        || o_matched_value !== want_res.matched_value) begin
                    report($sformatf("got st=%0d xor=%h val=%h, want st=%0d xor=%h val=%h",
                                     o_status, o_best_xor, o_matched_value,
                                     want_res.status, want_res.best_xor,
                                     want_res.matched_value));
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("max_xor_binary_trie_core: mismatch");
            $finish;
        end
    end

    initial begin
        int                  r;
        int                  n;
        int                  sel;
        int                  rejects;
        logic [KEY_BITS-1:0] key;
        t_status             last_st;

        errors      = 0;
        cycle_count = 0;
        burst_left  = $urandom_range(1, 24);
        gap_left    = 0;
        free_node   = 1;
        kid_link[0][0] = 0;
        kid_link[0][1] = 0;

        start     <= 1'b0;
        i_func    <= OP_INSERT;
        i_operand <= KEY_ZERO;
        i_rst_n   <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (r = 0; r < DIR_COUNT; r++) begin
            send_item(dir_rows[r].op, dir_rows[r].key, dir_rows[r].typed,
                      dir_rows[r].res, last_st);
        end
        wait_for_drain();

        // Mixed inserts and queries on a growing trie
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                send_item(OP_INSERT, rand_key(), 1'b0, NO_RES, last_st);
            end else if (sel < 50) begin
                send_item(OP_INSERT, near_key(pick_stored(), KEY_BITS - 1), 1'b0, NO_RES,
                          last_st);
            end else if (sel < 58) begin
                send_item(OP_INSERT, pick_stored(), 1'b0, NO_RES, last_st);
            end else if (sel < 88) begin
                send_item(OP_QUERY, rand_key(), 1'b0, NO_RES, last_st);
            end else begin
                key = ($urandom_range(0, 1) == 0) ? pick_stored()
                                                  : near_key(pick_stored(), 6);
                send_item(OP_QUERY, key, 1'b0, NO_RES, last_st);
            end
            if (n == RANDOM_ITEMS / 2) wait_for_drain();
        end
        wait_for_drain();

        // Fill the node pool until inserts are turned away
        rejects = 0;
        for (n = 0; n < FILL_CAP && rejects < FULL_REJECTS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                send_item(OP_QUERY, rand_key(), 1'b0, NO_RES, last_st);
            end else begin
                key = (sel < 75) ? rand_bits() : near_key(pick_stored(), 8);
                send_item(OP_INSERT, key, 1'b0, NO_RES, last_st);
                if (last_st == ST_FULL) rejects++;
            end
            if (n % 500 == 499) wait_for_drain();
        end
        wait_for_drain();

        // Full pool: duplicates, short tails, rejects and queries
        for (n = 0; n < POST_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                send_item(OP_QUERY, rand_key(), 1'b0, NO_RES, last_st);
            end else if (sel < 60) begin
                send_item(OP_INSERT, pick_stored(), 1'b0, NO_RES, last_st);
            end else if (sel < 85) begin
                send_item(OP_INSERT, rand_key(), 1'b0, NO_RES, last_st);
            end else begin
                send_item(OP_INSERT, near_key(pick_stored(), 3), 1'b0, NO_RES, last_st);
            end
        end

        // Let the last results arrive, then allow the block to settle
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (errors == 0) begin
            $display("max_xor_binary_trie_core: match");
        end else begin
            $display("max_xor_binary_trie_core: mismatch");
        end
        $finish;
    end

endmodule

[max_xor_binary_trie_core.f]
+incdir+rtl
rtl/mxt_pkg.sv
rtl/mxt_ctrl.sv
rtl/mxt_datapath.sv
rtl/max_xor_binary_trie_core.sv
tb/max_xor_binary_trie_core_tb.sv
